FILE: hw/rtl/tsq_pkg.sv
package tsq_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int SAMPLE_MAX = 4095;
  localparam int COUNT_W    = 32;
  localparam int IN_DATA_W  = 6 * SAMPLE_W;
  localparam int CFG_IDX_W  = 2;
  localparam int FRAMES_W   = 2;

  localparam int POINTS_PER_FRAME_DEF = 4;
  localparam int SCREEN_COLUMNS_DEF   = 320;
  localparam int SCREEN_ROWS_DEF      = 240;
  localparam int RAW_LOW_DEF          = 250;
  localparam int RAW_HIGH_DEF         = 3850;

  localparam int BUTTON_ROW  = 180;
  localparam int LEFT_EDGE   = 106;
  localparam int MIDDLE_EDGE = 210;

  localparam logic [SAMPLE_W-1:0] VALID_LOW_RST    = 12'd150;
  localparam logic [SAMPLE_W-1:0] VALID_HIGH_RST   = 12'd3950;
  localparam logic [SAMPLE_W-1:0] SPREAD_LIMIT_RST = 12'd70;
  localparam logic [FRAMES_W-1:0] FRAMES_RST       = 2'd2;
  localparam logic [FRAMES_W-1:0] STABLE_MAX       = 2'd3;
  localparam logic [SAMPLE_W-1:0] SAMPLE_TOP       = 12'd4095;

  localparam logic [CFG_IDX_W-1:0] CFG_VALID_LOW     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VALID_HIGH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPREAD_LIMIT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_NEEDED = 2'd3;

  typedef enum logic [1:0] {
    BTN_NONE   = 2'd0,
    BTN_LEFT   = 2'd1,
    BTN_MIDDLE = 2'd2,
    BTN_RIGHT  = 2'd3
  } button_t;

endpackage

FILE: hw/rtl/tsq_best_pair.sv
module tsq_best_pair (
  input  logic [tsq_pkg::SAMPLE_W-1:0] a,
  input  logic [tsq_pkg::SAMPLE_W-1:0] b,
  input  logic [tsq_pkg::SAMPLE_W-1:0] c,
  output logic [tsq_pkg::SAMPLE_W-1:0] filt
);
  import tsq_pkg::*;

  logic [SAMPLE_W-1:0] d_ab, d_ac, d_bc;
  logic [SAMPLE_W:0]   pair_sum;

  assign d_ab = (a > b) ? a - b : b - a;
  assign d_ac = (a > c) ? a - c : c - a;
  assign d_bc = (b > c) ? b - c : c - b;

  always_comb begin
    if (d_ab <= d_ac && d_ab <= d_bc) begin
      pair_sum = {1'b0, a} + {1'b0, b};
    end else if (d_ac <= d_ab && d_ac <= d_bc) begin
      pair_sum = {1'b0, a} + {1'b0, c};
    end else begin
      pair_sum = {1'b0, b} + {1'b0, c};
    end
  end

  assign filt = pair_sum[SAMPLE_W:1];

endmodule

FILE: hw/rtl/touch_sample_qualifier_core.sv
// channel | ports                          | payload
// input   | in_tvalid in_tready in_tdata   | one point reading, three x and three y conversions
// result  | out_tvalid out_tready out_tdata | one frame summary per POINTS_PER_FRAME items
// config  | cfg_wr_en cfg_index cfg_wdata  | window, spread limit, frames needed
//
// one item accepted per cycle unless results stall, through an eight-register pipeline
// a frame result passes the accumulate, average, qualify, mapping and output registers
// the mapping stages use two multipliers per axis in separate stages
// synchronous reset restores config defaults and clears frame and stable state
// a stalled result backs the pipeline up one stage at a time, bubbles fill first
module touch_sample_qualifier_core #(
  parameter int POINTS_PER_FRAME = tsq_pkg::POINTS_PER_FRAME_DEF,
  parameter int SCREEN_COLUMNS   = tsq_pkg::SCREEN_COLUMNS_DEF,
  parameter int SCREEN_ROWS      = tsq_pkg::SCREEN_ROWS_DEF,
  parameter int RAW_LOW          = tsq_pkg::RAW_LOW_DEF,
  parameter int RAW_HIGH         = tsq_pkg::RAW_HIGH_DEF,
  localparam int SX_W       = $clog2(SCREEN_COLUMNS),
  localparam int SY_W       = $clog2(SCREEN_ROWS),
  localparam int OUT_RAW_W  = 4 * tsq_pkg::SAMPLE_W + 5 + SX_W + SY_W + 2 + tsq_pkg::COUNT_W,
  localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // x_first, x_second, x_third, y_first, y_second, y_third
  input  logic [tsq_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // avg_x, avg_y, spread_x, spread_y, in_window, is_stable, stable_count,
  // reported, screen_x, screen_y, button, touch_count, zero fill
  output logic [OUT_DATA_W-1:0]             out_tdata,
  input  logic                              cfg_wr_en,
  input  logic [tsq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tsq_pkg::SAMPLE_W-1:0]      cfg_wdata
);
  import tsq_pkg::*;

  localparam int SUM_W      = $clog2(POINTS_PER_FRAME * SAMPLE_MAX + 1);
  localparam int IDX_W      = $clog2(POINTS_PER_FRAME);
  localparam int AVG_SH     = SUM_W + $clog2(POINTS_PER_FRAME);
  localparam int AVG_MUL_W  = SUM_W + 1;
  localparam int AVG_PROD_W = SUM_W + AVG_MUL_W;
  localparam logic [AVG_MUL_W-1:0] AVG_MUL = AVG_MUL_W'(
    ((64'd1 << AVG_SH) + 64'(POINTS_PER_FRAME) - 64'd1) / 64'(POINTS_PER_FRAME));

  localparam int MAP_N_W    = 2 * SAMPLE_W;
  localparam int RAW_SPAN   = RAW_HIGH - RAW_LOW;
  localparam int MAP_SH     = MAP_N_W + $clog2(RAW_SPAN);
  localparam int MAP_MUL_W  = MAP_N_W + 1;
  localparam int MAP_PROD_W = MAP_N_W + MAP_MUL_W;
  localparam logic [MAP_MUL_W-1:0] MAP_MUL = MAP_MUL_W'(
    ((64'd1 << MAP_SH) + 64'(RAW_SPAN) - 64'd1) / 64'(RAW_SPAN));

  localparam logic [SAMPLE_W-1:0] COL_LAST = SAMPLE_W'(SCREEN_COLUMNS - 1);
  localparam logic [SAMPLE_W-1:0] ROW_LAST = SAMPLE_W'(SCREEN_ROWS - 1);
  localparam logic [SAMPLE_W-1:0] RAW_LOW_V = SAMPLE_W'(RAW_LOW);
  localparam logic [IDX_W-1:0]    LAST_IDX  = IDX_W'(POINTS_PER_FRAME - 1);

  typedef struct packed {
    logic [SAMPLE_W-1:0] avg_x;
    logic [SAMPLE_W-1:0] avg_y;
    logic [SAMPLE_W-1:0] spread_x;
    logic [SAMPLE_W-1:0] spread_y;
    logic                in_window;
    logic                is_stable;
    logic [FRAMES_W-1:0] stable_count;
    logic                reported;
    logic [COUNT_W-1:0]  touch_count;
  } frame_info_t;

  // config registers
  logic [SAMPLE_W-1:0] valid_low_r, valid_high_r, spread_limit_r;
  logic [FRAMES_W-1:0] frames_needed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_low_r     <= VALID_LOW_RST;
      valid_high_r    <= VALID_HIGH_RST;
      spread_limit_r  <= SPREAD_LIMIT_RST;
      frames_needed_r <= FRAMES_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_VALID_LOW:     valid_low_r     <= cfg_wdata;
        CFG_VALID_HIGH:    valid_high_r    <= cfg_wdata;
        CFG_SPREAD_LIMIT:  spread_limit_r  <= cfg_wdata;
        CFG_FRAMES_NEEDED: frames_needed_r <= cfg_wdata[FRAMES_W-1:0];
        default: ;
      endcase
    end
  end

  // stage valids and ready chain
  logic v0_r, v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, out_valid_r;
  logic rdy0, rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy_out;

  assign rdy_out = !out_valid_r || out_tready;
  assign rdy6    = !v6_r || rdy_out;
  assign rdy5    = !v5_r || rdy6;
  assign rdy4    = !v4_r || rdy5;
  assign rdy3    = !v3_r || rdy4;
  assign rdy2    = !v2_r || rdy3;
  assign rdy1    = !v1_r || rdy2;
  assign rdy0    = !v0_r || rdy1;

  assign in_tready  = rdy0;
  assign out_tvalid = out_valid_r;

  logic [IDX_W-1:0] pt_idx_r;
  logic fire1, fire3, last_pt;
  assign fire1   = v1_r && rdy2;
  assign fire3   = v3_r && rdy4;
  assign last_pt = (pt_idx_r == LAST_IDX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy0) v0_r <= in_tvalid;
      if (rdy1) v1_r <= v0_r;
      if (rdy2) v2_r <= v1_r && last_pt;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
      if (rdy6) v6_r <= v5_r;
      if (rdy_out) out_valid_r <= v6_r;
    end
  end

  // input register
  logic [2:0][SAMPLE_W-1:0] s0_x_r, s0_y_r;

  always_ff @(posedge clk) begin
    if (rdy0) begin
      s0_x_r <= in_tdata[3*SAMPLE_W-1:0];
      s0_y_r <= in_tdata[6*SAMPLE_W-1:3*SAMPLE_W];
    end
  end

  // closest pair per axis
  logic [SAMPLE_W-1:0] filt_x, filt_y;
  logic [SAMPLE_W-1:0] s1_fx_r, s1_fy_r;

  tsq_best_pair u_pair_x (
    .a    (s0_x_r[0]),
    .b    (s0_x_r[1]),
    .c    (s0_x_r[2]),
    .filt (filt_x)
  );

  tsq_best_pair u_pair_y (
    .a    (s0_y_r[0]),
    .b    (s0_y_r[1]),
    .c    (s0_y_r[2]),
    .filt (filt_y)
  );

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_fx_r <= filt_x;
      s1_fy_r <= filt_y;
    end
  end

  // frame accumulation
  logic [SUM_W-1:0]    sum_x_r, sum_y_r, sum_x_nxt, sum_y_nxt;
  logic [SAMPLE_W-1:0] lo_x_r, hi_x_r, lo_y_r, hi_y_r;
  logic [SAMPLE_W-1:0] lo_x_nxt, hi_x_nxt, lo_y_nxt, hi_y_nxt;

  assign sum_x_nxt = sum_x_r + SUM_W'(s1_fx_r);
  assign sum_y_nxt = sum_y_r + SUM_W'(s1_fy_r);
  assign lo_x_nxt  = (s1_fx_r < lo_x_r) ? s1_fx_r : lo_x_r;
  assign hi_x_nxt  = (s1_fx_r > hi_x_r) ? s1_fx_r : hi_x_r;
  assign lo_y_nxt  = (s1_fy_r < lo_y_r) ? s1_fy_r : lo_y_r;
  assign hi_y_nxt  = (s1_fy_r > hi_y_r) ? s1_fy_r : hi_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n || (fire1 && last_pt)) begin
      pt_idx_r <= '0;
      sum_x_r  <= '0;
      sum_y_r  <= '0;
      lo_x_r   <= SAMPLE_TOP;
      hi_x_r   <= '0;
      lo_y_r   <= SAMPLE_TOP;
      hi_y_r   <= '0;
    end else if (fire1) begin
      pt_idx_r <= pt_idx_r + 1'b1;
      sum_x_r  <= sum_x_nxt;
      sum_y_r  <= sum_y_nxt;
      lo_x_r   <= lo_x_nxt;
      hi_x_r   <= hi_x_nxt;
      lo_y_r   <= lo_y_nxt;
      hi_y_r   <= hi_y_nxt;
    end
  end

  logic [SUM_W-1:0]    s2_sum_x_r, s2_sum_y_r;
  logic [SAMPLE_W-1:0] s2_lo_x_r, s2_hi_x_r, s2_lo_y_r, s2_hi_y_r;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_sum_x_r <= sum_x_nxt;
      s2_sum_y_r <= sum_y_nxt;
      s2_lo_x_r  <= lo_x_nxt;
      s2_hi_x_r  <= hi_x_nxt;
      s2_lo_y_r  <= lo_y_nxt;
      s2_hi_y_r  <= hi_y_nxt;
    end
  end

  // average by reciprocal multiply, spreads
  logic [AVG_PROD_W-1:0] avg_x_prod, avg_y_prod;
  logic [SAMPLE_W-1:0]   s3_avg_x_r, s3_avg_y_r, s3_spr_x_r, s3_spr_y_r;

  assign avg_x_prod = AVG_PROD_W'(s2_sum_x_r) * AVG_PROD_W'(AVG_MUL);
  assign avg_y_prod = AVG_PROD_W'(s2_sum_y_r) * AVG_PROD_W'(AVG_MUL);

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_avg_x_r <= SAMPLE_W'(avg_x_prod >> AVG_SH);
      s3_avg_y_r <= SAMPLE_W'(avg_y_prod >> AVG_SH);
      s3_spr_x_r <= s2_hi_x_r - s2_lo_x_r;
      s3_spr_y_r <= s2_hi_y_r - s2_lo_y_r;
    end
  end

  // qualification and stable-frame state
  logic [FRAMES_W-1:0] stable_cnt_r, cnt_nxt;
  logic [COUNT_W-1:0]  touch_total_r, touch_nxt;
  logic                win, stab, rep_nxt;
  frame_info_t         info_nxt, s4_info_r, s5_info_r, s6_info_r;
  logic [SAMPLE_W-1:0] s4_dx_r, s4_dy_r;

  assign win = (s3_avg_x_r > valid_low_r) && (s3_avg_x_r < valid_high_r) &&
               (s3_avg_y_r > valid_low_r) && (s3_avg_y_r < valid_high_r);
  assign stab = (s3_spr_x_r < spread_limit_r) && (s3_spr_y_r < spread_limit_r);

  always_comb begin
    if (!(win && stab)) begin
      cnt_nxt = '0;
    end else if (stable_cnt_r == STABLE_MAX) begin
      cnt_nxt = STABLE_MAX;
    end else begin
      cnt_nxt = stable_cnt_r + 1'b1;
    end
  end

  assign rep_nxt   = (cnt_nxt >= frames_needed_r);
  assign touch_nxt = touch_total_r + COUNT_W'(rep_nxt);

  always_comb begin
    info_nxt.avg_x        = s3_avg_x_r;
    info_nxt.avg_y        = s3_avg_y_r;
    info_nxt.spread_x     = s3_spr_x_r;
    info_nxt.spread_y     = s3_spr_y_r;
    info_nxt.in_window    = win;
    info_nxt.is_stable    = stab;
    info_nxt.stable_count = cnt_nxt;
    info_nxt.reported     = rep_nxt;
    info_nxt.touch_count  = touch_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_cnt_r  <= '0;
      touch_total_r <= '0;
    end else if (fire3) begin
      stable_cnt_r  <= cnt_nxt;
      touch_total_r <= touch_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      s4_info_r <= info_nxt;
      s4_dx_r   <= (s3_avg_x_r > RAW_LOW_V) ? s3_avg_x_r - RAW_LOW_V : '0;
      s4_dy_r   <= (s3_avg_y_r > RAW_LOW_V) ? s3_avg_y_r - RAW_LOW_V : '0;
    end
  end

  // screen mapping
  logic [MAP_N_W-1:0]    s5_px_r, s5_py_r;
  logic [MAP_PROD_W-1:0] s6_qx_r, s6_qy_r;

  always_ff @(posedge clk) begin
    if (rdy5) begin
      s5_info_r <= s4_info_r;
      s5_px_r   <= MAP_N_W'(s4_dx_r) * MAP_N_W'(COL_LAST);
      s5_py_r   <= MAP_N_W'(s4_dy_r) * MAP_N_W'(ROW_LAST);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy6) begin
      s6_info_r <= s5_info_r;
      s6_qx_r   <= MAP_PROD_W'(s5_px_r) * MAP_PROD_W'(MAP_MUL);
      s6_qy_r   <= MAP_PROD_W'(s5_py_r) * MAP_PROD_W'(MAP_MUL);
    end
  end

  logic [MAP_N_W-1:0]  qx, qy;
  logic [SAMPLE_W-1:0] scr_x, scr_y, scr_x_out, scr_y_out;
  button_t             btn;

  assign qx    = MAP_N_W'(s6_qx_r >> MAP_SH);
  assign qy    = MAP_N_W'(s6_qy_r >> MAP_SH);
  assign scr_x = (qx > MAP_N_W'(COL_LAST)) ? COL_LAST : qx[SAMPLE_W-1:0];
  assign scr_y = (qy > MAP_N_W'(ROW_LAST)) ? ROW_LAST : qy[SAMPLE_W-1:0];

  always_comb begin
    scr_x_out = '0;
    scr_y_out = '0;
    btn       = BTN_NONE;
    if (s6_info_r.reported) begin
      scr_x_out = scr_x;
      scr_y_out = scr_y;
      if (scr_y >= SAMPLE_W'(BUTTON_ROW)) begin
        if (scr_x < SAMPLE_W'(LEFT_EDGE)) begin
          btn = BTN_LEFT;
        end else if (scr_x < SAMPLE_W'(MIDDLE_EDGE)) begin
          btn = BTN_MIDDLE;
        end else begin
          btn = BTN_RIGHT;
        end
      end
    end
  end

  logic [OUT_DATA_W-1:0] out_tdata_r;

  always_ff @(posedge clk) begin
    if (rdy_out) begin
      out_tdata_r <= OUT_DATA_W'({s6_info_r.touch_count, btn,
                                  scr_y_out[SY_W-1:0], scr_x_out[SX_W-1:0],
                                  s6_info_r.reported, s6_info_r.stable_count,
                                  s6_info_r.is_stable, s6_info_r.in_window,
                                  s6_info_r.spread_y, s6_info_r.spread_x,
                                  s6_info_r.avg_y, s6_info_r.avg_x});
    end
  end

  assign out_tdata = out_tdata_r;

  a_point_index: assert property (@(posedge clk) disable iff (!rst_n)
    pt_idx_r <= LAST_IDX)
    else $error("point index past end of frame");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_valid_r && !out_tready))
    else $error("input stalled while pipeline has room");

  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    v6_r |-> (scr_x <= COL_LAST) && (scr_y <= ROW_LAST))
    else $error("screen coordinate out of range");

  a_report_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && s4_info_r.reported) |->
      ((s4_info_r.in_window && s4_info_r.is_stable) || (frames_needed_r == '0)))
    else $error("touch reported on an unqualified frame");

endmodule

FILE: test/touch_sample_qualifier_core_test.sv
module touch_sample_qualifier_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tsq_pkg::*;

  localparam int HOLD_CYCLES = 80;
  localparam int FRAMES_PER_PHASE = 40;

  typedef struct packed {
    logic [SAMPLE_W-1:0] y_third;
    logic [SAMPLE_W-1:0] y_second;
    logic [SAMPLE_W-1:0] y_first;
    logic [SAMPLE_W-1:0] x_third;
    logic [SAMPLE_W-1:0] x_second;
    logic [SAMPLE_W-1:0] x_first;
  } reading_t;

  typedef struct packed {
    logic [COUNT_W-1:0]  touch_count;
    button_t             button;
    logic [7:0]          screen_y;
    logic [8:0]          screen_x;
    logic                reported;
    logic [1:0]          stable_count;
    logic                is_stable;
    logic                in_window;
    logic [SAMPLE_W-1:0] spread_y;
    logic [SAMPLE_W-1:0] spread_x;
    logic [SAMPLE_W-1:0] avg_y;
    logic [SAMPLE_W-1:0] avg_x;
  } frame_summary_t;

  localparam int SUMMARY_W = $bits(frame_summary_t);

  class touch_scoreboard;
    logic [SAMPLE_W-1:0] valid_low, valid_high, spread_limit;
    logic [FRAMES_W-1:0] frames_needed;
    int                  points_seen;
    logic [SAMPLE_W-1:0] min_x, max_x, min_y, max_y;
    logic [13:0]         sum_x, sum_y;
    logic [1:0]          stable_frames;
    logic [COUNT_W-1:0]  touches;
    frame_summary_t      pending_summaries[$];
    int                  errors;

    function new();
      valid_low = VALID_LOW_RST;
      valid_high = VALID_HIGH_RST;
      spread_limit = SPREAD_LIMIT_RST;
      frames_needed = FRAMES_RST;
      stable_frames = '0;
      touches = '0;
      errors = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      points_seen = 0;
      min_x = SAMPLE_TOP;
      max_x = '0;
      min_y = SAMPLE_TOP;
      max_y = '0;
      sum_x = '0;
      sum_y = '0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [SAMPLE_W-1:0] value);
      case (idx)
        CFG_VALID_LOW: valid_low = value;
        CFG_VALID_HIGH: valid_high = value;
        CFG_SPREAD_LIMIT: spread_limit = value;
        CFG_FRAMES_NEEDED: frames_needed = value[FRAMES_W-1:0];
        default: ;
      endcase
    endfunction

    // mean of the two closest conversions, ties to first/second then first/third
    function logic [SAMPLE_W-1:0] closest_pair_mean(logic [SAMPLE_W-1:0] a,
                                                     logic [SAMPLE_W-1:0] b,
                                                     logic [SAMPLE_W-1:0] c);
      logic [SAMPLE_W-1:0] ab, ac, bc;
      logic [SAMPLE_W:0]   total;
      ab = a > b ? a - b : b - a;
      ac = a > c ? a - c : c - a;
      bc = b > c ? b - c : c - b;
      if (ab <= ac && ab <= bc) begin
        total = {1'b0, a} + b;
      end else if (ac <= ab && ac <= bc) begin
        total = {1'b0, a} + c;
      end else begin
        total = {1'b0, b} + c;
      end
      return total[SAMPLE_W:1];
    endfunction

    function int to_screen(logic [SAMPLE_W-1:0] avg, int span);
      int v;
      if (avg <= RAW_LOW_DEF) return 0;
      v = (int'(avg) - RAW_LOW_DEF) * (span - 1) / (RAW_HIGH_DEF - RAW_LOW_DEF);
      if (v > span - 1) v = span - 1;
      return v;
    endfunction

    function void note_reading(reading_t r);
      logic [SAMPLE_W-1:0] fx, fy;
      frame_summary_t      s;
      int                  scx, scy;
      fx = closest_pair_mean(r.x_first, r.x_second, r.x_third);
      fy = closest_pair_mean(r.y_first, r.y_second, r.y_third);
      if (fx < min_x) min_x = fx;
      if (fx > max_x) max_x = fx;
      if (fy < min_y) min_y = fy;
      if (fy > max_y) max_y = fy;
      sum_x = sum_x + fx;
      sum_y = sum_y + fy;
      points_seen++;
      if (points_seen < POINTS_PER_FRAME_DEF) return;

      s = '0;
      s.avg_x = SAMPLE_W'(sum_x / POINTS_PER_FRAME_DEF);
      s.avg_y = SAMPLE_W'(sum_y / POINTS_PER_FRAME_DEF);
      s.spread_x = max_x - min_x;
      s.spread_y = max_y - min_y;
      s.in_window = s.avg_x > valid_low && s.avg_x < valid_high &&
                    s.avg_y > valid_low && s.avg_y < valid_high;
      s.is_stable = s.spread_x < spread_limit && s.spread_y < spread_limit;
      if (s.in_window && s.is_stable) begin
        if (stable_frames < STABLE_MAX) stable_frames++;
      end else begin
        stable_frames = '0;
      end
      s.stable_count = stable_frames;
      s.reported = stable_frames >= frames_needed;
      if (s.reported) begin
        touches++;
        scx = to_screen(s.avg_x, SCREEN_COLUMNS_DEF);
        scy = to_screen(s.avg_y, SCREEN_ROWS_DEF);
        s.screen_x = scx[8:0];
        s.screen_y = scy[7:0];
        if (scy >= BUTTON_ROW) begin
          if (scx < LEFT_EDGE) s.button = BTN_LEFT;
          else if (scx < MIDDLE_EDGE) s.button = BTN_MIDDLE;
          else s.button = BTN_RIGHT;
        end
      end
      s.touch_count = touches;
      pending_summaries.push_back(s);
      clear_frame();
    endfunction

    task report_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    task compare_field(string name, longint unsigned got, longint unsigned want);
      if (got != want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task check_summary(logic [SUMMARY_W-1:0] raw);
      frame_summary_t got, want;
      if (pending_summaries.size() == 0) begin
        report_mismatch("frame summary with no frame pending");
        return;
      end
      got = frame_summary_t'(raw);
      want = pending_summaries.pop_front();
      compare_field("avg_x", got.avg_x, want.avg_x);
      compare_field("avg_y", got.avg_y, want.avg_y);
      compare_field("spread_x", got.spread_x, want.spread_x);
      compare_field("spread_y", got.spread_y, want.spread_y);
      compare_field("in_window", got.in_window, want.in_window);
      compare_field("is_stable", got.is_stable, want.is_stable);
      compare_field("stable_count", got.stable_count, want.stable_count);
      compare_field("reported", got.reported, want.reported);
      compare_field("screen_x", got.screen_x, want.screen_x);
      compare_field("screen_y", got.screen_y, want.screen_y);
      compare_field("button", got.button, want.button);
      compare_field("touch_count", got.touch_count, want.touch_count);
    endtask

    task flag_leftovers();
      if (pending_summaries.size() != 0)
        report_mismatch($sformatf("%0d frame summaries never arrived",
                                  pending_summaries.size()));
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [SUMMARY_W-1:0] out_tdata;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SAMPLE_W-1:0]  cfg_wdata = '0;

  touch_scoreboard book;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_asked = 0;
  int hold_served = 0;
  int hold_left = 0;

  touch_sample_qualifier_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: check accepted summaries, then choose next ready
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) book.check_summary(out_tdata);
    if (hold_asked != hold_served) begin
      hold_served = hold_served + 1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  initial begin
    #3_000_000;
    $display("Verification failed");
    $finish;
  end

  task automatic push_reading(reading_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= r;
    do @(posedge clk); while (!in_tready);
    book.note_reading(r);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [SAMPLE_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    book.set_register(idx, value);
  endtask

  task automatic settle();
    int waited;
    waited = 0;
    in_tvalid <= 1'b0;
    while (book.pending_summaries.size() != 0 && waited < 50000) begin
      @(posedge clk);
      waited++;
    end
    repeat (16) @(posedge clk);
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0: begin send_idle_pct = 19; recv_stall_pct = 74; end
      1: begin send_idle_pct = 74; recv_stall_pct = 19; end
      default: begin send_idle_pct = 0; recv_stall_pct = 0; end
    endcase
  endtask

  function automatic reading_t mk(int x1, int x2, int x3, int y1, int y2, int y3);
    reading_t r;
    r.x_first = SAMPLE_W'(x1);
    r.x_second = SAMPLE_W'(x2);
    r.x_third = SAMPLE_W'(x3);
    r.y_first = SAMPLE_W'(y1);
    r.y_second = SAMPLE_W'(y2);
    r.y_third = SAMPLE_W'(y3);
    return r;
  endfunction

  function automatic int near(int c, int jit);
    int v;
    v = c + int'($urandom_range(0, 2 * jit)) - jit;
    if (v < 0) v = 0;
    if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    return v;
  endfunction

  function automatic reading_t noise_reading();
    logic [95:0] bits;
    bits = {$urandom(), $urandom(), $urandom()};
    return reading_t'(bits[IN_DATA_W-1:0]);
  endfunction

  task automatic send_touch_frame(int cx, int cy, int jit, bit wild, int real_points);
    reading_t r;
    for (int i = 0; i < POINTS_PER_FRAME_DEF; i++) begin
      if (i < real_points) begin
        r = mk(near(cx, jit), near(cx, jit), near(cx, jit),
               near(cy, jit), near(cy, jit), near(cy, jit));
        // occasional stray conversion that the pair pick should reject
        if (wild && $urandom_range(0, 2) == 0) begin
          if ($urandom_range(0, 1) == 0) r.x_second = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
          else r.y_third = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
        end
      end else begin
        r = noise_reading();
      end
      push_reading(r);
    end
  endtask

  task automatic run_random_phase(bit squeeze);
    int frames_left, kind, cx, cy, jit, run_len;
    frames_left = FRAMES_PER_PHASE;
    if (squeeze) hold_asked <= hold_asked + 1;
    while (frames_left > 0) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        cx = $urandom_range(0, SAMPLE_MAX);
        cy = $urandom_range(0, SAMPLE_MAX);
        jit = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 200) : $urandom_range(0, 25);
        run_len = $urandom_range(1, 6);
        for (int f = 0; f < run_len && frames_left > 0; f++) begin
          send_touch_frame(cx, cy, jit, $urandom_range(0, 3) == 0, POINTS_PER_FRAME_DEF);
          frames_left--;
        end
      end else if (kind < 9) begin
        send_touch_frame(0, 0, 0, 1'b0, 0);
        frames_left--;
      end else begin
        send_touch_frame($urandom_range(0, SAMPLE_MAX), $urandom_range(0, SAMPLE_MAX),
                         10, 1'b0, $urandom_range(1, 3));
        frames_left--;
      end
    end
  endtask

  initial begin
    logic [SAMPLE_W-1:0] vl, vh, sl;
    logic [1:0]          fn;
    book = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes and pair ties under reset settings, then stable touches
    set_idling(0);
    push_reading(mk(0, 0, 0, 0, 0, 0));
    push_reading(mk(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX));
    push_reading(mk(0, 10, 20, 100, 0, 5));
    push_reading(mk(0, 20, 10, 4095, 4085, 4075));
    for (int i = 0; i < 4; i++) push_reading(mk(2000, 2000, 2000, 3500, 3500, 3500));
    for (int i = 0; i < 4; i++) push_reading(mk(800, 800, 800, 3500, 3500, 3500));
    for (int i = 0; i < 4; i++) push_reading(mk(2000, 2000, 2000, 3500, 3500, 3500));
    for (int i = 0; i < 4; i++) push_reading(mk(3700, 3700, 3700, 3500, 3500, 3500));
    for (int i = 0; i < 4; i++) push_reading(mk(200, 200, 200, 200, 200, 200));
    settle();

    for (int p = 1; p <= 8; p++) begin
      case (p)
        1: begin vl = '0; vh = SAMPLE_TOP; sl = SAMPLE_TOP; fn = 2'd1; end
        2: begin vl = SAMPLE_TOP; vh = '0; sl = '0; fn = 2'd0; end
        3: begin vl = VALID_LOW_RST; vh = VALID_HIGH_RST; sl = SPREAD_LIMIT_RST; fn = 2'd3; end
        default: begin
          vl = SAMPLE_W'($urandom_range(0, 1000));
          vh = SAMPLE_W'($urandom_range(3000, SAMPLE_MAX));
          sl = SAMPLE_W'($urandom_range(0, 300));
          fn = 2'($urandom_range(0, 3));
        end
      endcase
      write_register(CFG_VALID_LOW, vl);
      write_register(CFG_VALID_HIGH, vh);
      write_register(CFG_SPREAD_LIMIT, sl);
      // upper bits of the frames register are don't-care
      write_register(CFG_FRAMES_NEEDED, {10'($urandom()), fn});
      cfg_wr_en <= 1'b0;
      set_idling((p - 1) % 3);
      run_random_phase((p - 1) % 3 == 2);
      settle();
    end

    book.flag_leftovers();
    if (book.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: touch_sample_qualifier_core.f
hw/rtl/tsq_pkg.sv
hw/rtl/tsq_best_pair.sv
hw/rtl/touch_sample_qualifier_core.sv
test/touch_sample_qualifier_core_test.sv
